FILE: hdl/neighbor_weight_select_macros.svh
// Assertion macros for the neighbour weight selector.
// Depends on nothing; the asserting module provides clk and arst_n.
`ifndef NEIGHBOR_WEIGHT_SELECT_MACROS_SVH
`define NEIGHBOR_WEIGHT_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define NWS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NWS_ASSERT_SAME(label, ante, cons, msg)
`define NWS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/nws_pkg.sv
// Shared types and constants of the neighbour weight selector.
// Depends on nothing; used by nws_cell and neighbor_weight_select.
package nws_pkg;

	localparam int ROW_LEN_DEF = 64;
	localparam int K_MAX_DEF   = 16;
	localparam int RESULT_CAP  = 16;

	localparam int DIST_W   = 32;
	localparam int IDX_W    = 6;
	localparam int KCOUNT_W = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic MODE_KNN     = 1'b0;
	localparam logic MODE_EPSILON = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SELECT_MODE    = 2'd0,
		CFG_NEIGHBOR_COUNT = 2'd1,
		CFG_EPSILON        = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} nws_state_t;

	// One list slot as seen by a neighbouring cell.
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  col;
	} nws_entry_t;

	// Operation broadcast to every cell; at most one is set in a cycle.
	typedef struct packed {
		logic insert;
		logic trim;
		logic clear;
		logic drain;
	} nws_ctl_t;

endpackage

FILE: hdl/nws_cell.sv
// One compare-and-insert cell of the sorted neighbour list.
// Depends on nws_pkg for the entry and control types.
module nws_cell import nws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  nws_ctl_t          ctl,
	input  logic              keep,
	input  logic [DIST_W-1:0] new_dist,
	input  logic [IDX_W-1:0]  new_col,
	input  logic              prev_lt,
	input  nws_entry_t        prev_entry,
	input  nws_entry_t        next_entry,
	output logic              lt,
	output nws_entry_t        entry
);

	logic              valid_q;
	logic [DIST_W-1:0] dist_q;
	logic [IDX_W-1:0]  col_q;

	// An empty slot loses to any word; an equal distance keeps the older column.
	assign lt = !valid_q || (new_dist < dist_q);

	assign entry = '{valid: valid_q, distance: dist_q, col: col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (!keep) begin
				valid_q <= 1'b0;
			end else if (prev_lt) begin
				valid_q <= prev_entry.valid;
			end else if (lt) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.trim) begin
			if (!keep) begin
				valid_q <= 1'b0;
			end
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && keep) begin
			if (prev_lt) begin
				dist_q <= prev_entry.distance;
				col_q  <= prev_entry.col;
			end else if (lt) begin
				dist_q <= new_dist;
				col_q  <= new_col;
			end
		end else if (ctl.drain) begin
			dist_q <= next_entry.distance;
			col_q  <= next_entry.col;
		end
	end

endmodule

FILE: hdl/neighbor_weight_select.sv
// Neighbour weight selector: k nearest neighbours or epsilon threshold per row.
// Depends on nws_pkg, nws_cell and neighbor_weight_select_macros.svh.
// An epsilon-mode weight is registered and appears in the cycle after its word is taken; in kNN mode
// the kept neighbours of a row are shifted out of cell zero after the row-end word and registered.
// Throughput: one word per cycle within a row, as the cell chain inserts in a single step;
// busy stays high in the EMIT state that follows a kNN row end, also when the list is empty.
// Reset empties the list, zeroes the column count and loads mode 0, k = 1, epsilon = 0.
// Results cannot be held off by the receiver; each is shown for exactly one cycle.
`include "neighbor_weight_select_macros.svh"
module neighbor_weight_select import nws_pkg::*; #(
	parameter int ROW_LEN = ROW_LEN_DEF,
	parameter int K_MAX   = K_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_data,
	// input word
	input  logic                 start,
	output logic                 busy,
	input  logic [DIST_W-1:0]    distance,
	input  logic [IDX_W-1:0]     row_index,
	input  logic                 row_end,
	// result word
	output logic                 result_strobe,
	output logic [IDX_W-1:0]     neighbor_index,
	output logic [DIST_W-1:0]    weight,
	output logic                 last_of_run
);

	localparam int CNT_W = $clog2(ROW_LEN);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int KCAP  = (K_MAX < RESULT_CAP) ? K_MAX : RESULT_CAP;

	// Configuration registers.
	logic                select_mode_q;
	logic [KCOUNT_W-1:0] neighbor_count_q;
	logic [DIST_W-1:0]   epsilon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_mode_q    <= MODE_KNN;
			neighbor_count_q <= KCOUNT_W'(1);
			epsilon_q        <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SELECT_MODE:    select_mode_q    <= cfg_data[0];
				CFG_NEIGHBOR_COUNT: neighbor_count_q <= cfg_data[KCOUNT_W-1:0];
				CFG_EPSILON:        epsilon_q        <= cfg_data;
				default:            ;
			endcase
		end
	end

	// The programmed k is held between one and the number of cells that may be emitted.
	logic [KCOUNT_W-1:0] k_eff;

	always_comb begin
		k_eff = neighbor_count_q;
		if (k_eff == '0) begin
			k_eff = KCOUNT_W'(1);
		end
		if (k_eff > KCOUNT_W'(KCAP)) begin
			k_eff = KCOUNT_W'(KCAP);
		end
	end

	// Column counter and the decode of the current word.
	logic [CNT_W-1:0] col_q;
	logic [CMP_W-1:0] col_wide;
	logic [IDX_W-1:0] col_idx;
	logic             is_self;
	logic             is_end;
	logic             accept;

	assign accept   = start && !busy;
	assign col_wide = CMP_W'(col_q);
	assign col_idx  = col_wide[IDX_W-1:0];
	// A column beyond the index range can never be the row's own point.
	assign is_self  = (col_wide == CMP_W'(row_index));
	// A row closes on the flag or when the counter reaches the last column.
	assign is_end   = row_end || (col_q == CNT_W'(ROW_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			if (is_end) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// Control: IDLE takes words, EMIT shifts the list out of cell zero one entry a cycle.
	nws_state_t state_q;
	nws_state_t state_d;
	nws_ctl_t   cell_ctl;
	nws_entry_t cell_entry [K_MAX];
	logic       cell_lt [K_MAX];
	logic       head_valid;
	logic       head_last;

	assign head_valid = cell_entry[0].valid;
	// The entry behind the head being empty makes the head the row's final result.
	assign head_last  = (K_MAX > 1) ? !cell_entry[(K_MAX > 1) ? 1 : 0].valid : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		cell_ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (select_mode_q == MODE_KNN) begin
						// Insertion also drops slots beyond k; a self word only trims at row end.
						cell_ctl.insert = !is_self;
						cell_ctl.trim   = is_self && is_end;
						if (is_end) begin
							state_d = ST_EMIT;
						end
					end else begin
						cell_ctl.clear = is_end;
					end
				end
			end
			ST_EMIT: begin
				busy           = 1'b1;
				cell_ctl.drain = 1'b1;
				if (!head_valid || head_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The chain of cells: each compares the broadcast word and takes its left neighbour
	// when a shift opens, or the right neighbour while draining.
	for (genvar g = 0; g < K_MAX; g++) begin : g_cell
		logic       keep;
		logic       prev_lt;
		nws_entry_t prev_entry;
		nws_entry_t next_entry;

		assign keep = (32'(g) < 32'(k_eff));

		if (g == 0) begin : g_first
			assign prev_lt    = 1'b0;
			assign prev_entry = '0;
		end else begin : g_inner
			assign prev_lt    = cell_lt[g-1];
			assign prev_entry = cell_entry[g-1];
		end

		if (g == K_MAX - 1) begin : g_last
			assign next_entry = '0;
		end else begin : g_mid
			assign next_entry = cell_entry[g+1];
		end

		nws_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.keep       (keep),
			.new_dist   (distance),
			.new_col    (col_idx),
			.prev_lt    (prev_lt),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.lt         (cell_lt[g]),
			.entry      (cell_entry[g])
		);
	end

	// Result register, fed either by the threshold path or by the head of the chain.
	logic              strobe_q;
	logic [IDX_W-1:0]  neighbor_index_q;
	logic [DIST_W-1:0] weight_q;
	logic              last_of_run_q;
	logic              eps_fire;
	logic              knn_fire;

	assign eps_fire = accept && (select_mode_q == MODE_EPSILON);
	assign knn_fire = (state_q == ST_EMIT) && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= eps_fire || knn_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (eps_fire) begin
			neighbor_index_q <= col_idx;
			// The self entry passes through; others are cut below epsilon.
			weight_q         <= (is_self || (distance >= epsilon_q)) ? distance : '0;
			last_of_run_q    <= is_end;
		end else if (knn_fire) begin
			neighbor_index_q <= cell_entry[0].col;
			weight_q         <= cell_entry[0].distance;
			last_of_run_q    <= head_last;
		end
	end

	assign result_strobe  = strobe_q;
	assign neighbor_index = neighbor_index_q;
	assign weight         = weight_q;
	assign last_of_run    = last_of_run_q;

	`NWS_ASSERT_NEXT(a_eps_result, eps_fire, result_strobe, "threshold word gave no result")
	`NWS_ASSERT_NEXT(a_emit_stops, (state_q == ST_EMIT) && !head_valid, !busy, "emission overran")
	`NWS_ASSERT_SAME(a_ctl_exclusive, 1'b1, $onehot0(cell_ctl), "cell operations overlap")
	`NWS_ASSERT_SAME(a_list_sorted, cell_entry[0].valid && cell_entry[K_MAX-1].valid, cell_entry[0].distance <= cell_entry[K_MAX-1].distance, "list out of order")

endmodule

FILE: test/tb.sv
// Self-checking testbench for neighbor_weight_select: kNN selection and epsilon thresholding.
// Depends on nws_pkg and the RTL of neighbor_weight_select; stimulus and checks are built in.
module tb;
	import nws_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted word, result or register write before the run is abandoned.
	// The slowest legal stretch is the longest random gap, a full list drain and the settling pause.
	localparam int STALL_LIMIT = 2000;

	// One expected result word.
	typedef struct packed {
		logic [IDX_W-1:0]  column;
		logic [DIST_W-1:0] weight;
		logic              last;
	} edge_word_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_write;
	cfg_reg_t            cfg_index;
	logic [DIST_W-1:0]   cfg_data;
	logic                start;
	logic                busy;
	logic [DIST_W-1:0]   distance;
	logic [IDX_W-1:0]    row_index;
	logic                row_end;
	logic                result_strobe;
	logic [IDX_W-1:0]    neighbor_index;
	logic [DIST_W-1:0]   weight;
	logic                last_of_run;

	// Shadow copies of the configuration registers, updated on the write edge.
	logic                shadow_mode;
	logic [KCOUNT_W-1:0] shadow_k;
	logic [DIST_W-1:0]   shadow_eps;

	// Predicted contents of the sorted neighbour list and the column position in the row.
	logic [DIST_W-1:0]   best_dist [K_MAX_DEF];
	logic [IDX_W-1:0]    best_col  [K_MAX_DEF];
	int                  list_fill;
	int                  column_count;

	edge_word_t          pending_edges[$];
	int                  error_count = 0;
	int                  words_sent  = 0;
	int                  idle_cycles = 0;
	// When set, the sender offers each word straight after the previous one.
	logic                no_gaps = 1'b0;

	neighbor_weight_select u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_list();
		for (int i = 0; i < K_MAX_DEF; i++) begin
			best_dist[i] = '1;
			best_col[i]  = '0;
		end
		list_fill = 0;
	endfunction

	// Appends one expected result word behind those already waiting.
	function automatic void add_expected(input edge_word_t e);
		pending_edges.insert(pending_edges.size(), e);
	endfunction

	// Works out the result words caused by one accepted input word and queues them.
	// In epsilon mode every word yields one weight at once. In kNN mode the word is
	// inserted into the sorted list (an equal distance stays behind the earlier column)
	// and the whole list is released, smallest first, when the row ends.
	function automatic void predict_edges(input logic [DIST_W-1:0] dist_val,
		input logic [IDX_W-1:0] row, input logic last_col);
		logic       row_done;
		logic       is_self;
		int         k;
		int         n;
		int         pos;
		int         i;
		edge_word_t e;
		// A row also closes on its own once the last column position is reached.
		row_done = last_col || (column_count >= ROW_LEN_DEF - 1);
		is_self  = (column_count == int'(row));
		if (shadow_mode == MODE_EPSILON) begin
			// The self column passes through regardless of the threshold.
			e.column = IDX_W'(column_count);
			e.weight = (is_self || dist_val >= shadow_eps) ? dist_val : '0;
			e.last   = row_done;
			add_expected(e);
		end else begin
			// A count of zero acts as one; anything above the list depth acts as the depth.
			k = int'(shadow_k);
			if (k < 1)
				k = 1;
			if (k > K_MAX_DEF)
				k = K_MAX_DEF;
			if (!is_self) begin
				// A k lowered since the last insertion trims the list here.
				if (list_fill > k)
					list_fill = k;
				pos = list_fill;
				while (pos > 0 && best_dist[pos-1] > dist_val)
					pos--;
				if (pos < k) begin
					i = (list_fill < k) ? list_fill : k - 1;
					while (i > pos) begin
						best_dist[i] = best_dist[i-1];
						best_col[i]  = best_col[i-1];
						i--;
					end
					best_dist[pos] = dist_val;
					best_col[pos]  = IDX_W'(column_count);
					if (list_fill < k)
						list_fill++;
				end
			end
			// An empty list at the row end gives no result at all.
			if (row_done) begin
				n = (list_fill < k) ? list_fill : k;
				for (i = 0; i < n; i++) begin
					e.column = best_col[i];
					e.weight = best_dist[i];
					e.last   = (i == n - 1);
					add_expected(e);
				end
			end
		end
		// The list is cleared at every row end, whichever mode is then in force.
		if (row_done) begin
			clear_list();
			column_count = 0;
		end else begin
			column_count++;
		end
	endfunction

	// Offers one input word after a random gap and waits until the block takes it.
	task automatic send_word(input logic [DIST_W-1:0] dist_val, input logic [IDX_W-1:0] row,
		input logic last_col);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start     = 1'b1;
		distance  = dist_val;
		row_index = row;
		row_end   = last_col;
		do begin
			@(posedge clk);
		end while (busy);
		predict_edges(dist_val, row, last_col);
		words_sent++;
	endtask

	// Stops offering words, lets every expected result arrive and then gives the cell
	// chain time to finish a drain that produces nothing (an empty list at row end).
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (K_MAX_DEF + 4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [DIST_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		case (idx)
			CFG_SELECT_MODE:    shadow_mode = data[0];
			CFG_NEIGHBOR_COUNT: shadow_k    = data[KCOUNT_W-1:0];
			CFG_EPSILON:        shadow_eps  = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Mostly legal counts, the two ends of the range, and now and then zero or values
	// beyond the list depth, which the block clamps.
	function automatic logic [DIST_W-1:0] pick_k();
		case ($urandom_range(0, 5))
			0: return 1;
			1: return K_MAX_DEF;
			2: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
			default: return $urandom_range(1, K_MAX_DEF);
		endcase
	endfunction

	// Default registers after reset: k of one in kNN mode. The self column at position 0
	// is skipped, and of two equal maximal distances the lower column is kept.
	task automatic test_reset_defaults();
		send_word(32'h0000_0000, 6'd0, 1'b0);
		send_word(32'hFFFF_FFFF, 6'd0, 1'b0);
		send_word(32'hFFFF_FFFF, 6'd0, 1'b1);
	endtask

	// Ascending order with ties: two equal distances keep their column order.
	task automatic test_knn_order_and_ties();
		settle();
		write_register(CFG_NEIGHBOR_COUNT, 32'd3);
		send_word(32'd5, 6'd63, 1'b0);
		send_word(32'd5, 6'd63, 1'b0);
		send_word(32'd3, 6'd63, 1'b0);
		send_word(32'd5, 6'd63, 1'b1);
	endtask

	// A row holding only its self column gives nothing; a row with fewer other columns
	// than k gives all of them.
	task automatic test_short_rows();
		send_word(32'd9, 6'd0, 1'b1);
		send_word(32'd7, 6'd1, 1'b0);
		send_word(32'd2, 6'd1, 1'b1);
	endtask

	// A count of zero acts as one, and the widest count acts as the full list depth.
	task automatic test_k_clamp();
		settle();
		write_register(CFG_NEIGHBOR_COUNT, 32'd0);
		send_word(32'd9, 6'd5, 1'b0);
		send_word(32'd4, 6'd5, 1'b1);
		settle();
		write_register(CFG_NEIGHBOR_COUNT, 32'd31);
		send_word(32'd2, 6'd63, 1'b0);
		send_word(32'd1, 6'd63, 1'b0);
		send_word(32'd3, 6'd63, 1'b1);
	endtask

	// Threshold edges: just below, exactly at, a self entry below it, and the top value.
	task automatic test_epsilon_threshold();
		settle();
		write_register(CFG_SELECT_MODE, 32'(MODE_EPSILON));
		write_register(CFG_EPSILON, 32'h0001_0000);
		send_word(32'h0000_FFFF, 6'd2, 1'b0);
		send_word(32'h0001_0000, 6'd2, 1'b0);
		send_word(32'h0000_0005, 6'd2, 1'b0);
		send_word(32'h0000_0000, 6'd2, 1'b1);
		settle();
		write_register(CFG_EPSILON, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 6'd63, 1'b0);
		send_word(32'hFFFF_FFFE, 6'd63, 1'b1);
	endtask

	// Mode switched to epsilon and back inside one kNN row, then k lowered before the
	// row closes: epsilon words must not enter the list, and the list is trimmed.
	task automatic test_mode_change_in_row();
		settle();
		write_register(CFG_SELECT_MODE, 32'(MODE_KNN));
		write_register(CFG_NEIGHBOR_COUNT, 32'd3);
		send_word(32'd8, 6'd1, 1'b0);
		send_word(32'd2, 6'd1, 1'b0);
		settle();
		write_register(CFG_SELECT_MODE, 32'(MODE_EPSILON));
		write_register(CFG_EPSILON, 32'd0);
		send_word(32'd6, 6'd1, 1'b0);
		settle();
		write_register(CFG_SELECT_MODE, 32'(MODE_KNN));
		write_register(CFG_NEIGHBOR_COUNT, 32'd1);
		send_word(32'd1, 6'd1, 1'b1);
	endtask

	// One row of random length and content. Most rows are short; about one in ten runs
	// the full length and may close without row_end. Distances favour small values so
	// that ties are common. Now and then the row is interrupted to change k and maybe the mode.
	task automatic send_random_row();
		int                len;
		int                mid;
		logic [IDX_W-1:0]  row;
		logic [DIST_W-1:0] dist_val;
		logic              last_col;
		len = ($urandom_range(0, 9) == 0) ? ROW_LEN_DEF : $urandom_range(1, 20);
		row = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, len - 1))
		                                   : IDX_W'($urandom_range(0, 63));
		mid = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : -1;
		for (int c = 0; c < len; c++) begin
			if (c == mid) begin
				settle();
				write_register(CFG_NEIGHBOR_COUNT, pick_k());
				if ($urandom_range(0, 1) == 0)
					write_register(CFG_SELECT_MODE, 32'(~shadow_mode));
			end
			case ($urandom_range(0, 5))
				0: dist_val = '0;
				1: dist_val = '1;
				2: dist_val = DIST_W'($urandom_range(0, 7));
				3: dist_val = DIST_W'($urandom_range(0, 7)) << 16;
				default: dist_val = $urandom;
			endcase
			if (c != len - 1)
				last_col = 1'b0;
			else if (len == ROW_LEN_DEF)
				last_col = 1'($urandom_range(0, 1));
			else
				last_col = 1'b1;
			send_word(dist_val, row, last_col);
		end
	endtask

	// Random phases: each picks a fresh configuration and a pacing, then sends a few rows.
	task automatic test_random_rows();
		int goal;
		goal = words_sent + 160;
		while (words_sent < goal) begin
			settle();
			write_register(CFG_SELECT_MODE,
				($urandom_range(0, 3) == 0) ? 32'(MODE_EPSILON) : 32'(MODE_KNN));
			write_register(CFG_NEIGHBOR_COUNT, pick_k());
			case ($urandom_range(0, 3))
				0: write_register(CFG_EPSILON, '0);
				1: write_register(CFG_EPSILON, '1);
				2: write_register(CFG_EPSILON, DIST_W'($urandom_range(0, 7)) << 16);
				default: write_register(CFG_EPSILON, $urandom);
			endcase
			no_gaps = ($urandom_range(0, 2) == 0);
			repeat ($urandom_range(1, 4)) send_random_row();
		end
		no_gaps = 1'b0;
	endtask

	// Each result word is compared with the oldest expectation. The block cannot hold
	// results off, so a strobe seen at a rising edge is a word taken at that edge.
	always @(posedge clk) begin
		edge_word_t want;
		if (result_strobe) begin
			if (pending_edges.size() == 0) begin
				$error("unexpected result word: neighbor_index %0d weight %h last_of_run %b",
					neighbor_index, weight, last_of_run);
				error_count++;
			end else begin
				want = pending_edges.pop_front();
				if (neighbor_index !== want.column) begin
					$error("neighbor_index: expected %0d, actual %0d", want.column,
						neighbor_index);
					error_count++;
				end
				if (weight !== want.weight) begin
					$error("weight: expected %h, actual %h", want.weight, weight);
					error_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %b, actual %b", want.last, last_of_run);
					error_count++;
				end
			end
		end
	end

	// Watchdog: any accepted word, result or register write counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || cfg_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_SELECT_MODE;
		cfg_data  = '0;
		distance  = '0;
		row_index = '0;
		row_end   = 1'b0;
		// The shadow state starts from the block's reset values.
		shadow_mode  = MODE_KNN;
		shadow_k     = KCOUNT_W'(1);
		shadow_eps   = '0;
		column_count = 0;
		clear_list();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_knn_order_and_ties();
		test_short_rows();
		test_k_clamp();
		test_epsilon_threshold();
		test_mode_change_in_row();
		test_random_rows();

		// Drain whatever is still on its way, then a short tail for stray strobes.
		settle();
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
